FILE: hdl/kts_pkg.sv
// shared constants, stat indexes and key code helpers for the keystroke stats block
`timescale 1ns / 1ps
package kts_pkg;

  localparam int KEY_SLOTS = 768;
  localparam int SLOT_AW   = $clog2(KEY_SLOTS);
  localparam int CODE_W    = 10;
  localparam int VAL_W     = 2;
  localparam int TIME_W    = 64;
  localparam int CNT_W     = 32;
  localparam int IDX_W     = 4;

  localparam logic [CODE_W:0] SLOT_LIMIT = (CODE_W+1)'(KEY_SLOTS);

  // key_value codes
  localparam logic [VAL_W-1:0] KV_RELEASE = 2'd0;
  localparam logic [VAL_W-1:0] KV_PRESS   = 2'd1;
  localparam logic [VAL_W-1:0] KV_REPEAT  = 2'd2;

  // func codes
  localparam logic FN_KEY  = 1'b0;
  localparam logic FN_TICK = 1'b1;

  // key codes with special meaning
  localparam logic [CODE_W-1:0] KEY_BKSP      = 10'd14;
  localparam logic [CODE_W-1:0] KEY_W         = 10'd17;
  localparam logic [CODE_W-1:0] KEY_LCTRL     = 10'd29;
  localparam logic [CODE_W-1:0] KEY_RCTRL     = 10'd97;
  localparam logic [CODE_W-1:0] KEY_LALT      = 10'd56;
  localparam logic [CODE_W-1:0] KEY_RALT      = 10'd100;

  // stat indexes of a tick's run
  localparam logic [IDX_W-1:0] ST_PRESS     = 4'd0;
  localparam logic [IDX_W-1:0] ST_RELEASE   = 4'd1;
  localparam logic [IDX_W-1:0] ST_CHAR      = 4'd2;
  localparam logic [IDX_W-1:0] ST_CHARDEL   = 4'd3;
  localparam logic [IDX_W-1:0] ST_WORDDEL   = 4'd4;
  localparam logic [IDX_W-1:0] ST_HOLD_SUM  = 4'd5;
  localparam logic [IDX_W-1:0] ST_HOLD_CNT  = 4'd6;
  localparam logic [IDX_W-1:0] ST_HOLD_M2   = 4'd7;
  localparam logic [IDX_W-1:0] ST_HOLD_MAX  = 4'd8;
  localparam logic [IDX_W-1:0] ST_GAP_SUM   = 4'd9;
  localparam logic [IDX_W-1:0] ST_GAP_CNT   = 4'd10;
  localparam logic [IDX_W-1:0] ST_GAP_M2    = 4'd11;
  localparam logic [IDX_W-1:0] ST_GAP_MIN   = 4'd12;
  localparam logic [IDX_W-1:0] ST_GAP_MAX   = 4'd13;

  function automatic logic is_printable(input logic [CODE_W-1:0] c);
    return (c >= 10'd2  && c <= 10'd13) || (c >= 10'd16 && c <= 10'd27) ||
           (c >= 10'd30 && c <= 10'd41) || (c >= 10'd43 && c <= 10'd53) ||
           (c == 10'd57);
  endfunction

  function automatic logic [TIME_W-1:0] sat_add64(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

FILE: hdl/keystroke_timing_stats.sv
// top level of the keystroke timing statistics block
`timescale 1ns / 1ps
// keystroke timing statistics
//
// input channel (in_*): one beat is a key event (in_func low) or a one-second
// tick (in_func high). in_ready is high only while the sequencer is idle.
// output channel (out_*): a tick produces a run of 14 beats, stat indexes 0
// through 13, out_last on the final one. the live bucket clears after the
// final beat is taken.
// the first beat of a run is registered and shown the cycle after the tick.
// a press with no gap, a repeat or an out-of-range code goes straight back
// to idle; a release reads the press-time memory and goes back with no hold.
// a press with a gap or a release with a hold runs one sample through the
// shared divider for the old mean (skipped while the count is zero) and the
// new mean, and through the shared 32x32 multiplier three times.
// receiver stall: out_valid and the beat hold until out_ready; no input is
// taken until the run is done.
// reset: after rst_n the block sweeps the 768-entry press-time memory to
// zero, one entry a cycle, with in_ready low.
module keystroke_timing_stats (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [kts_pkg::CODE_W-1:0]    in_key_code,
  input  logic [kts_pkg::VAL_W-1:0]     in_key_value,
  input  logic [kts_pkg::TIME_W-1:0]    in_time_ns,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kts_pkg::IDX_W-1:0]     out_stat_index,
  output logic [kts_pkg::TIME_W-1:0]    out_stat_value,
  output logic                          out_last
);
  import kts_pkg::*;

  // sequencer states
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_OLD   = 4'd3;
  localparam logic [3:0] S_OWAIT = 4'd4;
  localparam logic [3:0] S_NEW   = 4'd5;
  localparam logic [3:0] S_NDIV  = 4'd6;
  localparam logic [3:0] S_NWAIT = 4'd7;
  localparam logic [3:0] S_M0    = 4'd8;
  localparam logic [3:0] S_M1    = 4'd9;
  localparam logic [3:0] S_M2    = 4'd10;
  localparam logic [3:0] S_ACC   = 4'd11;
  localparam logic [3:0] S_SPR   = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  localparam logic SEL_HOLD = 1'b0;
  localparam logic SEL_GAP  = 1'b1;

  logic [3:0]         state_r;
  logic [SLOT_AW-1:0] clr_cnt_r;

  // latched event
  logic [CODE_W-1:0] code_r;
  logic [TIME_W-1:0] now_r;

  // sample datapath
  logic              sel_r;
  logic [TIME_W-1:0] x_r;
  logic [TIME_W-1:0] omean_r;
  logic [TIME_W-1:0] d1_r;
  logic [TIME_W-1:0] d2_r;
  logic [TIME_W-1:0] prod_r;
  logic [TIME_W-1:0] mul_r;
  logic [CNT_W-1:0]  mul_a;
  logic [CNT_W-1:0]  mul_b;

  // key state and live bucket
  logic [TIME_W-1:0] last_press_r;
  logic              ctrl_r;
  logic              alt_r;
  logic [CNT_W-1:0]  ev_r [5];
  logic [TIME_W-1:0] sum_r [2];
  logic [CNT_W-1:0]  num_r [2];
  logic [TIME_W-1:0] m2_r [2];
  logic [TIME_W-1:0] hold_max_r;
  logic [TIME_W-1:0] gap_min_r;
  logic [TIME_W-1:0] gap_max_r;

  // output beat
  logic              out_valid_r;
  logic [IDX_W-1:0]  idx_r;

  // press-time memory
  logic [TIME_W-1:0]  pt_mem [KEY_SLOTS];
  logic [TIME_W-1:0]  rd_q_r;
  logic               mem_we;
  logic [SLOT_AW-1:0] mem_waddr;
  logic [TIME_W-1:0]  mem_wdata;

  // divider
  logic              div_start;
  logic              div_done;
  logic [TIME_W-1:0] div_quot;

  logic              in_fire;
  logic              out_fire;
  logic              in_range;
  logic              is_press;
  logic              have_gap;
  logic [TIME_W-1:0] gap_val;
  logic [TIME_W-1:0] hold_val;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign in_range = {1'b0, in_key_code} < SLOT_LIMIT;
  assign is_press = (in_key_value == KV_PRESS);
  assign have_gap = (last_press_r != '0) && (in_time_ns >= last_press_r);
  assign gap_val  = in_time_ns - last_press_r;
  assign hold_val = now_r - rd_q_r;

  assign in_ready = (state_r == S_IDLE);

  // memory write port: sweep, press store, or clear on release
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_key_code[SLOT_AW-1:0];
    mem_wdata = in_time_ns;
    if (state_r == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (state_r == S_RD) begin
      mem_we    = (rd_q_r != '0);
      mem_waddr = code_r[SLOT_AW-1:0];
      mem_wdata = '0;
    end else if (in_fire && in_func == FN_KEY && in_range && is_press) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) pt_mem[mem_waddr] <= mem_wdata;
    rd_q_r <= pt_mem[in_key_code[SLOT_AW-1:0]];
  end

  kts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r[sel_r]),
    .divisor  (num_r[sel_r]),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign div_start = (state_r == S_OLD && num_r[sel_r] != '0) || (state_r == S_NDIV);

  // shared 32x32 multiplier, low 64 bits of d1*d2 over three passes
  always_comb begin
    case (state_r)
      S_M0:    begin mul_a = d1_r[CNT_W-1:0];      mul_b = d2_r[CNT_W-1:0];      end
      S_M1:    begin mul_a = d1_r[CNT_W-1:0];      mul_b = d2_r[TIME_W-1:CNT_W]; end
      default: begin mul_a = d1_r[TIME_W-1:CNT_W]; mul_b = d2_r[CNT_W-1:0];      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_cnt_r    <= '0;
      last_press_r <= '0;
      ctrl_r       <= 1'b0;
      alt_r        <= 1'b0;
      for (int i = 0; i < 5; i++) ev_r[i] <= '0;
      for (int i = 0; i < 2; i++) begin
        sum_r[i] <= '0;
        num_r[i] <= '0;
        m2_r[i]  <= '0;
      end
      hold_max_r  <= '0;
      gap_min_r   <= '1;
      gap_max_r   <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      sel_r       <= SEL_HOLD;
    end else begin
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == SLOT_AW'(KEY_SLOTS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire) begin
            code_r <= in_key_code;
            now_r  <= in_time_ns;
            if (in_func == FN_TICK) begin
              out_valid_r <= 1'b1;
              idx_r       <= ST_PRESS;
              state_r     <= S_EMIT;
            end else if (in_key_value != KV_REPEAT && in_range) begin
              if (in_key_code == KEY_LCTRL || in_key_code == KEY_RCTRL) ctrl_r <= is_press;
              if (in_key_code == KEY_LALT || in_key_code == KEY_RALT) alt_r <= is_press;
              if (is_press) begin
                ev_r[0] <= ev_r[0] + 1'b1;
                if (is_printable(in_key_code)) ev_r[2] <= ev_r[2] + 1'b1;
                if (in_key_code == KEY_BKSP) begin
                  if (alt_r) ev_r[4] <= ev_r[4] + 1'b1;
                  else       ev_r[3] <= ev_r[3] + 1'b1;
                end else if (in_key_code == KEY_W && ctrl_r) begin
                  ev_r[4] <= ev_r[4] + 1'b1;
                end
                last_press_r <= in_time_ns;
                if (have_gap) begin
                  x_r   <= gap_val;
                  sel_r <= SEL_GAP;
                  if (gap_val < gap_min_r) gap_min_r <= gap_val;
                  if (gap_val > gap_max_r) gap_max_r <= gap_val;
                  state_r <= S_OLD;
                end
              end else begin
                ev_r[1] <= ev_r[1] + 1'b1;
                state_r <= S_RD;
              end
            end
          end
        end
        S_RD: begin
          // press time is read back; zero means no press pending
          if (rd_q_r != '0) begin
            x_r   <= hold_val;
            sel_r <= SEL_HOLD;
            if (hold_val > hold_max_r) hold_max_r <= hold_val;
            state_r <= S_OLD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_OLD: begin
          if (num_r[sel_r] != '0) begin
            state_r <= S_OWAIT;
          end else begin
            omean_r <= '0;
            state_r <= S_NEW;
          end
        end
        S_OWAIT: begin
          if (div_done) begin
            omean_r <= div_quot;
            state_r <= S_NEW;
          end
        end
        S_NEW: begin
          sum_r[sel_r] <= sat_add64(sum_r[sel_r], x_r);
          if (num_r[sel_r] != '1) num_r[sel_r] <= num_r[sel_r] + 1'b1;
          state_r <= S_NDIV;
        end
        S_NDIV: begin
          state_r <= S_NWAIT;
        end
        S_NWAIT: begin
          if (div_done) begin
            d1_r    <= x_r - omean_r;
            d2_r    <= x_r - div_quot;
            state_r <= S_M0;
          end
        end
        S_M0: state_r <= S_M1;
        S_M1: begin
          prod_r  <= mul_r;
          state_r <= S_M2;
        end
        S_M2: begin
          prod_r[TIME_W-1:CNT_W] <= prod_r[TIME_W-1:CNT_W] + mul_r[CNT_W-1:0];
          state_r <= S_ACC;
        end
        S_ACC: begin
          prod_r[TIME_W-1:CNT_W] <= prod_r[TIME_W-1:CNT_W] + mul_r[CNT_W-1:0];
          state_r <= S_SPR;
        end
        S_SPR: begin
          m2_r[sel_r] <= sat_add64(m2_r[sel_r], prod_r);
          state_r     <= S_IDLE;
        end
        S_EMIT: begin
          if (out_fire) begin
            if (idx_r == ST_GAP_MAX) begin
              // run done, close the bucket
              out_valid_r <= 1'b0;
              for (int i = 0; i < 5; i++) ev_r[i] <= '0;
              for (int i = 0; i < 2; i++) begin
                sum_r[i] <= '0;
                num_r[i] <= '0;
                m2_r[i]  <= '0;
              end
              hold_max_r <= '0;
              gap_min_r  <= '1;
              gap_max_r  <= '0;
              state_r    <= S_IDLE;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // stat selected by the beat index
  always_comb begin
    unique case (idx_r)
      ST_PRESS:    out_stat_value = {{(TIME_W-CNT_W){1'b0}}, ev_r[0]};
      ST_RELEASE:  out_stat_value = {{(TIME_W-CNT_W){1'b0}}, ev_r[1]};
      ST_CHAR:     out_stat_value = {{(TIME_W-CNT_W){1'b0}}, ev_r[2]};
      ST_CHARDEL:  out_stat_value = {{(TIME_W-CNT_W){1'b0}}, ev_r[3]};
      ST_WORDDEL:  out_stat_value = {{(TIME_W-CNT_W){1'b0}}, ev_r[4]};
      ST_HOLD_SUM: out_stat_value = sum_r[SEL_HOLD];
      ST_HOLD_CNT: out_stat_value = {{(TIME_W-CNT_W){1'b0}}, num_r[SEL_HOLD]};
      ST_HOLD_M2:  out_stat_value = m2_r[SEL_HOLD];
      ST_HOLD_MAX: out_stat_value = hold_max_r;
      ST_GAP_SUM:  out_stat_value = sum_r[SEL_GAP];
      ST_GAP_CNT:  out_stat_value = {{(TIME_W-CNT_W){1'b0}}, num_r[SEL_GAP]};
      ST_GAP_M2:   out_stat_value = m2_r[SEL_GAP];
      ST_GAP_MIN:  out_stat_value = gap_min_r;
      ST_GAP_MAX:  out_stat_value = gap_max_r;
      default:     out_stat_value = '0;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_stat_index = idx_r;
  assign out_last       = (idx_r == ST_GAP_MAX);

endmodule

FILE: hdl/kts_div.sv
// iterative restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle
`timescale 1ns / 1ps
module kts_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [kts_pkg::TIME_W-1:0]   dividend,
  input  logic [kts_pkg::CNT_W-1:0]    divisor,
  output logic                         done,
  output logic [kts_pkg::TIME_W-1:0]   quot
);
  import kts_pkg::*;

  localparam int STEP_W = $clog2(TIME_W);

  logic [TIME_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              fits;

  always_comb begin
    shifted = {rem_r, q_r[TIME_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = shifted >= {1'b0, dvs_r};
    rem_nxt = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
    q_nxt   = {q_r[TIME_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        q_r    <= q_nxt;
        rem_r  <= rem_nxt;
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(TIME_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: hdl/kts_checker.sv
// port-level checker for the keystroke stats block, bound to the top level
`timescale 1ns / 1ps
module kts_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [kts_pkg::IDX_W-1:0]     out_stat_index,
  input logic [kts_pkg::TIME_W-1:0]    out_stat_value,
  input logic                          out_last
);
  import kts_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_stat_index) &&
                                   $stable(out_stat_value)))
    else $error("stalled beat changed");

  a_no_input_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken during a run");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && out_stat_index == $past(out_stat_index) + 4'd1))
    else $error("run index did not step");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("beat after last");

  a_tick_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid)) |-> (out_stat_index == ST_PRESS))
    else $error("run did not start at index zero");

endmodule

bind keystroke_timing_stats kts_checker u_kts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_stat_index (out_stat_index),
  .out_stat_value (out_stat_value),
  .out_last       (out_last)
);
